// File: rtl/core/obd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and lookup functions for the OBD-II PID poller/decoder.
// No dependencies; imported by every module of the block.
package obd_pkg;

  localparam int unsigned NUM_PIDS_DEF = 5;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned NUM_QTY      = 5;

  localparam logic [15:0] PERIOD_RESET = 16'd100;

  localparam logic [10:0] RESP_ID_LO = 11'h7E8;
  localparam logic [10:0] RESP_ID_HI = 11'h7EF;
  localparam logic [3:0]  FRAME_LEN_MIN = 4'd4;
  localparam logic [3:0]  FRAME_LEN_TWO = 4'd5;
  localparam logic [7:0]  MODE_RESP  = 8'h41;
  localparam logic [7:0]  LEN_MIN    = 8'h03;

  localparam logic [7:0] PID_RPM        = 8'h0C;
  localparam logic [7:0] PID_SPEED      = 8'h0D;
  localparam logic [7:0] PID_LOAD       = 8'h04;
  localparam logic [7:0] PID_FUEL_LEVEL = 8'h2F;
  localparam logic [7:0] PID_FUEL_RATE  = 8'h5E;

  localparam logic [2:0] CODE_NONE       = 3'd0;
  localparam logic [2:0] CODE_RPM        = 3'd1;
  localparam logic [2:0] CODE_SPEED      = 3'd2;
  localparam logic [2:0] CODE_LOAD       = 3'd3;
  localparam logic [2:0] CODE_FUEL_LEVEL = 3'd4;
  localparam logic [2:0] CODE_FUEL_RATE  = 3'd5;

  // ceil(2^31 / 255) and ceil(2^22 / 5); exact for the operand ranges used
  localparam logic [23:0] RECIP_255   = 24'd8421505;
  localparam int unsigned RECIP_255_SH = 31;
  localparam logic [19:0] RECIP_5     = 20'd838861;
  localparam int unsigned RECIP_5_SH   = 22;

  typedef struct packed {
    logic                 accept;
    logic [2:0]           code;
    logic [23:0]          value;
    logic [NUM_QTY-1:0]   qty_hot;
  } dec_t;

  typedef struct packed {
    logic       due;
    logic       sent;
    logic [7:0] pid;
  } poll_t;

  // Round-robin request list; repeats after the fifth entry.
  function automatic logic [7:0] pid_at(input logic [POS_W-1:0] pos);
    logic [7:0] pid;
    unique case (pos)
      3'd0:    pid = PID_RPM;
      3'd1:    pid = PID_SPEED;
      3'd2:    pid = PID_LOAD;
      3'd3:    pid = PID_FUEL_LEVEL;
      3'd4:    pid = PID_FUEL_RATE;
      3'd5:    pid = PID_RPM;
      3'd6:    pid = PID_SPEED;
      3'd7:    pid = PID_LOAD;
      default: pid = PID_RPM;
    endcase
    return pid;
  endfunction

endpackage

// File: rtl/core/obd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
interface obd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_ms;
  logic        is_standard;
  logic [10:0] frame_id;
  logic [3:0]  frame_len;
  logic [7:0]  len_byte;
  logic [7:0]  mode_byte;
  logic [7:0]  pid_byte;
  logic [7:0]  value_a;
  logic [7:0]  value_b;
  logic        tx_ready;

  modport source (
    output valid, kind, now_ms, is_standard, frame_id, frame_len, len_byte,
           mode_byte, pid_byte, value_a, value_b, tx_ready,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, is_standard, frame_id, frame_len, len_byte,
           mode_byte, pid_byte, value_a, value_b, tx_ready,
    output ready
  );
endinterface

interface obd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  update_code;
  logic [23:0] update_value;
  logic [4:0]  valid_mask;
  logic        req_valid;
  logic [7:0]  req_pid;
  logic [31:0] rx_frame_count;
  logic [31:0] tx_request_count;
  logic [31:0] tx_error_count;
  logic [31:0] last_rx_time;

  modport source (
    output valid, update_code, update_value, valid_mask, req_valid, req_pid,
           rx_frame_count, tx_request_count, tx_error_count, last_rx_time,
    input  ready
  );
  modport sink (
    input  valid, update_code, update_value, valid_mask, req_valid, req_pid,
           rx_frame_count, tx_request_count, tx_error_count, last_rx_time,
    output ready
  );
endinterface

// File: rtl/core/obd_frame_dec.sv
`timescale 1ns / 1ps
// Response filter and mode 01 value decoder into unsigned Q16.8.
// Depends on obd_pkg.
module obd_frame_dec
  import obd_pkg::*;
(
  input  logic        is_frame,
  input  logic        is_standard,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_len,
  input  logic [7:0]  len_byte,
  input  logic [7:0]  mode_byte,
  input  logic [7:0]  pid_byte,
  input  logic [7:0]  value_a,
  input  logic [7:0]  value_b,
  output dec_t        dec
);

  logic        accept;
  logic        two_byte_ok;
  logic [15:0] n_val;
  logic [22:0] load_x;
  logic [46:0] load_p;
  logic [21:0] rate_x;
  logic [41:0] rate_p;
  logic [23:0] load_q;
  logic [23:0] rate_q;

  assign accept = is_frame && is_standard && (frame_id >= RESP_ID_LO) &&
                  (frame_id <= RESP_ID_HI) && (frame_len >= FRAME_LEN_MIN) &&
                  (mode_byte == MODE_RESP) && (len_byte >= LEN_MIN);
  assign two_byte_ok = frame_len >= FRAME_LEN_TWO;
  assign n_val = {value_a, value_b};

  // A * 25600 + 127 as shifts, then divide by 255 through the reciprocal
  assign load_x = (23'(value_a) << 14) + (23'(value_a) << 13) + (23'(value_a) << 10)
                + 23'd127;
  assign load_p = 47'(load_x) * 47'(RECIP_255);
  assign load_q = 24'(load_p >> RECIP_255_SH);

  // N * 64 + 2, divide by 5 through the reciprocal
  assign rate_x = {n_val, 6'b0} + 22'd2;
  assign rate_p = 42'(rate_x) * 42'(RECIP_5);
  assign rate_q = 24'(rate_p >> RECIP_5_SH);

  always_comb begin
    dec.accept  = accept;
    dec.code    = CODE_NONE;
    dec.value   = 24'd0;
    dec.qty_hot = '0;
    if (accept) begin
      unique case (pid_byte)
        PID_RPM: begin
          if (two_byte_ok) begin
            dec.code  = CODE_RPM;
            dec.value = {2'b0, n_val, 6'b0};
          end
        end
        PID_SPEED: begin
          dec.code  = CODE_SPEED;
          dec.value = {8'b0, value_a, 8'b0};
        end
        PID_LOAD: begin
          dec.code  = CODE_LOAD;
          dec.value = load_q;
        end
        PID_FUEL_LEVEL: begin
          dec.code  = CODE_FUEL_LEVEL;
          dec.value = load_q;
        end
        PID_FUEL_RATE: begin
          if (two_byte_ok) begin
            dec.code  = CODE_FUEL_RATE;
            dec.value = rate_q;
          end
        end
        default: begin
          dec.code = CODE_NONE;
        end
      endcase
    end
    if (dec.code != CODE_NONE) begin
      dec.qty_hot = NUM_QTY'(1) << (dec.code - 3'd1);
    end
  end

endmodule

// File: rtl/core/obd_poll_sched.sv
`timescale 1ns / 1ps
// Poll period register, elapsed-time check and round-robin PID selection.
// Depends on obd_pkg.
module obd_poll_sched
  import obd_pkg::*;
#(
  parameter int unsigned NUM_PIDS = NUM_PIDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        tick,
  input  logic [31:0] now_ms,
  input  logic        tx_ready,
  output poll_t       poll
);

  logic [15:0]      period;
  logic [31:0]      last_poll;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W:0]   pos_inc;
  logic [31:0]      elapsed;

  // wrapping subtraction gives elapsed time modulo 2^32
  assign elapsed = now_ms - last_poll;
  assign pos_inc = {1'b0, pos} + (POS_W+1)'(1);
  assign pos_next = (pos_inc >= (POS_W+1)'(NUM_PIDS)) ? '0 : pos_inc[POS_W-1:0];

  always_comb begin
    poll.due  = tick && (elapsed >= {16'b0, period});
    poll.sent = poll.due && tx_ready;
    poll.pid  = poll.sent ? pid_at(pos) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_RESET;
      last_poll <= '0;
      pos       <= '0;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      // a refused attempt still restarts the period but keeps the position
      if (poll.due) begin
        last_poll <= now_ms;
      end
      if (poll.sent) begin
        pos <= pos_next;
      end
    end
  end

endmodule

// File: rtl/core/obd_pid_poller_decoder_top.sv
`timescale 1ns / 1ps
// OBD-II mode 01 poller/decoder: input register, decode and poll logic, result register.
// Depends on obd_pkg, obd_if, obd_frame_dec and obd_poll_sched.
//
// Usage:
//   item    - valid/ready sink; each transfer is either a received CAN frame
//             (kind 0) or a poll tick (kind 1) with the current ms time.
//   result  - valid/ready source; exactly one result per item, in order,
//             carrying the decoded update, valid flags, request and counters.
//   cfg_wr_en / cfg_wr_data - write of poll_period_ms, taken on any clock edge
//             with cfg_wr_en high and rst low; write only while the block is idle.
// An accepted item is held in the input register, then in the result register
// (one input register stage, one result register stage).
// Throughput: one item per cycle when not stalled; the whole decode, including two
// constant reciprocal multiplies, and the poll check sit between the two registers.
// Reset (rst, synchronous) clears all counters, flags and poll state and sets
// the period to 100 ms; both register stages come out empty.
// When the receiver stalls the result holds, the input stage fills and then
// item.ready drops; no item is lost or reordered.
module obd_pid_poller_decoder_top
  import obd_pkg::*;
#(
  parameter int unsigned NUM_PIDS = NUM_PIDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  obd_in_if.sink       item,
  obd_out_if.source    result,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  // input register
  logic        s1_valid;
  logic        s1_kind;
  logic [31:0] s1_now;
  logic        s1_std;
  logic [10:0] s1_id;
  logic [3:0]  s1_len;
  logic [7:0]  s1_len_byte;
  logic [7:0]  s1_mode;
  logic [7:0]  s1_pid;
  logic [7:0]  s1_a;
  logic [7:0]  s1_b;
  logic        s1_tx_ready;

  // result register and block state
  logic               res_valid;
  logic [2:0]         res_code;
  logic [23:0]        res_value;
  logic               res_req;
  logic [7:0]         res_pid;
  logic [NUM_QTY-1:0] qty_valid;
  logic [31:0]        frames_seen;
  logic [31:0]        requests_sent;
  logic [31:0]        requests_failed;
  logic [31:0]        last_response_time;

  logic  out_free;
  logic  s1_adv;
  dec_t  dec;
  poll_t poll;

  assign out_free   = !res_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;

  obd_frame_dec u_dec (
    .is_frame    (!s1_kind),
    .is_standard (s1_std),
    .frame_id    (s1_id),
    .frame_len   (s1_len),
    .len_byte    (s1_len_byte),
    .mode_byte   (s1_mode),
    .pid_byte    (s1_pid),
    .value_a     (s1_a),
    .value_b     (s1_b),
    .dec         (dec)
  );

  obd_poll_sched #(
    .NUM_PIDS (NUM_PIDS)
  ) u_poll (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (s1_adv && s1_kind),
    .now_ms      (s1_now),
    .tx_ready    (s1_tx_ready),
    .poll        (poll)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind     <= item.kind;
      s1_now      <= item.now_ms;
      s1_std      <= item.is_standard;
      s1_id       <= item.frame_id;
      s1_len      <= item.frame_len;
      s1_len_byte <= item.len_byte;
      s1_mode     <= item.mode_byte;
      s1_pid      <= item.pid_byte;
      s1_a        <= item.value_a;
      s1_b        <= item.value_b;
      s1_tx_ready <= item.tx_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid          <= 1'b0;
      qty_valid          <= '0;
      frames_seen        <= '0;
      requests_sent      <= '0;
      requests_failed    <= '0;
      last_response_time <= '0;
    end else begin
      if (out_free) begin
        res_valid <= s1_valid;
      end
      if (s1_adv) begin
        qty_valid <= qty_valid | dec.qty_hot;
        if (!s1_kind) begin
          frames_seen <= frames_seen + 32'd1;
        end
        if (dec.accept) begin
          last_response_time <= s1_now;
        end
        if (poll.sent) begin
          requests_sent <= requests_sent + 32'd1;
        end
        if (poll.due && !poll.sent) begin
          requests_failed <= requests_failed + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_code  <= dec.code;
      res_value <= dec.value;
      res_req   <= poll.sent;
      res_pid   <= poll.pid;
    end
  end

  // state registers only move together with a result load, so they always
  // match the item held in the result register
  assign result.valid            = res_valid;
  assign result.update_code      = res_code;
  assign result.update_value     = res_value;
  assign result.valid_mask       = qty_valid;
  assign result.req_valid        = res_req;
  assign result.req_pid          = res_pid;
  assign result.rx_frame_count   = frames_seen;
  assign result.tx_request_count = requests_sent;
  assign result.tx_error_count   = requests_failed;
  assign result.last_rx_time     = last_response_time;

endmodule

// File: test/tb_obd_pid_poller_decoder_top.sv
`timescale 1ns / 1ps
// Testbench for obd_pid_poller_decoder_top: directed and random CAN frames and poll ticks,
// checked in order against a predictor of decode, poll and counter state.
// Depends on obd_pkg, obd_if and the block's RTL.
module tb_obd_pid_poller_decoder_top
  import obd_pkg::*;
;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        is_standard;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  len_byte;
    logic [7:0]  mode_byte;
    logic [7:0]  pid_byte;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic        tx_ready;
  } obd_item_t;

  typedef struct packed {
    logic [2:0]  update_code;
    logic [23:0] update_value;
    logic [4:0]  valid_mask;
    logic        req_valid;
    logic [7:0]  req_pid;
    logic [31:0] rx_frame_count;
    logic [31:0] tx_request_count;
    logic [31:0] tx_error_count;
    logic [31:0] last_rx_time;
  } obd_result_t;

  class obd_result_tracker;
    logic [15:0] period_ms;
    logic [23:0] qty_value [NUM_QTY];
    logic        qty_valid [NUM_QTY];
    logic [31:0] qty_stamp [NUM_QTY];
    logic [31:0] last_resp_ms;
    logic [31:0] frames_rx;
    logic [31:0] req_sent;
    logic [31:0] req_refused;
    logic [31:0] prev_poll_ms;
    int unsigned poll_idx;
    logic [7:0]  poll_pids [8];
    obd_result_t expected_results [$];
    int unsigned errors;

    function new();
      period_ms = PERIOD_RESET;
      for (int q = 0; q < NUM_QTY; q++) begin
        qty_value[q] = '0;
        qty_valid[q] = 1'b0;
        qty_stamp[q] = '0;
      end
      last_resp_ms = '0;
      frames_rx = '0;
      req_sent = '0;
      req_refused = '0;
      prev_poll_ms = '0;
      poll_idx = 0;
      poll_pids = '{PID_RPM, PID_SPEED, PID_LOAD, PID_FUEL_LEVEL, PID_FUEL_RATE,
                    PID_RPM, PID_SPEED, PID_LOAD};
      errors = 0;
    endfunction

    function void set_period(logic [15:0] p);
      period_ms = p;
    endfunction

    // Advance the state by one accepted item and queue the result it causes.
    function void note_item(obd_item_t it);
      obd_result_t r;
      logic [15:0] n;
      logic [31:0] a32;
      int slot;
      r = '0;
      n = {it.value_a, it.value_b};
      a32 = {24'd0, it.value_a};
      if (it.kind == KIND_FRAME) begin
        frames_rx++;
        if (it.is_standard && it.frame_id >= RESP_ID_LO && it.frame_id <= RESP_ID_HI &&
            it.frame_len >= FRAME_LEN_MIN && it.mode_byte == MODE_RESP &&
            it.len_byte >= LEN_MIN) begin
          case (it.pid_byte)
            PID_RPM: if (it.frame_len >= FRAME_LEN_TWO) begin
              r.update_code = CODE_RPM;
              r.update_value = {n, 6'd0};
            end
            PID_SPEED: begin
              r.update_code = CODE_SPEED;
              r.update_value = {it.value_a, 8'd0};
            end
            PID_LOAD: begin
              r.update_code = CODE_LOAD;
              r.update_value = 24'((a32 * 25600 + 127) / 255);
            end
            PID_FUEL_LEVEL: begin
              r.update_code = CODE_FUEL_LEVEL;
              r.update_value = 24'((a32 * 25600 + 127) / 255);
            end
            PID_FUEL_RATE: if (it.frame_len >= FRAME_LEN_TWO) begin
              r.update_code = CODE_FUEL_RATE;
              r.update_value = 24'(({16'd0, n} * 64 + 2) / 5);
            end
            default: ;
          endcase
          if (r.update_code != CODE_NONE) begin
            slot = r.update_code - 1;
            qty_value[slot] = r.update_value;
            qty_valid[slot] = 1'b1;
            qty_stamp[slot] = it.now_ms;
          end
          last_resp_ms = it.now_ms;
        end
      end else if (it.now_ms - prev_poll_ms >= {16'd0, period_ms}) begin
        // a refused attempt still restarts the period
        prev_poll_ms = it.now_ms;
        if (it.tx_ready) begin
          r.req_valid = 1'b1;
          r.req_pid = poll_pids[poll_idx & 7];
          req_sent++;
          poll_idx = (poll_idx + 1 >= NUM_PIDS_DEF) ? 0 : poll_idx + 1;
        end else begin
          req_refused++;
        end
      end
      for (int q = 0; q < NUM_QTY; q++)
        r.valid_mask[q] = qty_valid[q];
      r.rx_frame_count = frames_rx;
      r.tx_request_count = req_sent;
      r.tx_error_count = req_refused;
      r.last_rx_time = last_resp_ms;
      expected_results.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(obd_result_t got);
      obd_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      field_check("update_code", want.update_code, got.update_code);
      field_check("update_value", want.update_value, got.update_value);
      field_check("valid_mask", want.valid_mask, got.valid_mask);
      field_check("req_valid", want.req_valid, got.req_valid);
      field_check("req_pid", want.req_pid, got.req_pid);
      field_check("rx_frame_count", want.rx_frame_count, got.rx_frame_count);
      field_check("tx_request_count", want.tx_request_count, got.tx_request_count);
      field_check("tx_error_count", want.tx_error_count, got.tx_error_count);
      field_check("last_rx_time", want.last_rx_time, got.last_rx_time);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic [31:0] clock_ms;
  bit          quiet;
  int unsigned results_seen = 0;

  obd_in_if  item_if ();
  obd_out_if result_if ();

  obd_result_tracker tracker = new();

  obd_pid_poller_decoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_if),
    .result      (result_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && item_if.valid && item_if.ready)
      tracker.note_item({item_if.kind, item_if.now_ms, item_if.is_standard,
                         item_if.frame_id, item_if.frame_len, item_if.len_byte,
                         item_if.mode_byte, item_if.pid_byte, item_if.value_a,
                         item_if.value_b, item_if.tx_ready});
    if (!rst && result_if.valid && result_if.ready) begin
      tracker.check_result({result_if.update_code, result_if.update_value,
                            result_if.valid_mask, result_if.req_valid, result_if.req_pid,
                            result_if.rx_frame_count, result_if.tx_request_count,
                            result_if.tx_error_count, result_if.last_rx_time});
      results_seen++;
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the input.
  initial begin : result_sink
    int unsigned hold_left;
    bit long_done;
    hold_left = 0;
    long_done = 1'b0;
    result_if.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (!long_done && results_seen >= 200) begin
        hold_left = 80;
        long_done = 1'b1;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 10);
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  function automatic obd_item_t mk_frame(logic std, logic [10:0] id, logic [3:0] flen,
                                         logic [7:0] lbyte, logic [7:0] mode,
                                         logic [7:0] pid, logic [7:0] a, logic [7:0] b,
                                         logic [31:0] now);
    obd_item_t it;
    it = '0;
    it.kind = KIND_FRAME;
    it.is_standard = std;
    it.frame_id = id;
    it.frame_len = flen;
    it.len_byte = lbyte;
    it.mode_byte = mode;
    it.pid_byte = pid;
    it.value_a = a;
    it.value_b = b;
    it.now_ms = now;
    return it;
  endfunction

  function automatic obd_item_t mk_tick(logic [31:0] now, logic ready);
    obd_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.now_ms = now;
    it.tx_ready = ready;
    return it;
  endfunction

  // Mostly well-formed responses and ticks on a running clock; the rest is noise.
  function automatic obd_item_t next_random_item(logic [15:0] per);
    obd_item_t it;
    logic [95:0] noise;
    int unsigned pick;
    logic [7:0] pids [5];
    pids = '{PID_RPM, PID_SPEED, PID_LOAD, PID_FUEL_LEVEL, PID_FUEL_RATE};
    pick = $urandom_range(0, 99);
    if (pick < 3)
      clock_ms = $urandom();
    else if (pick < 5)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
    noise = {$urandom(), $urandom(), $urandom()};
    it = noise[$bits(obd_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      clock_ms += $urandom_range(0, 20);
      it.kind = KIND_FRAME;
      it.now_ms = clock_ms;
      it.is_standard = 1'b1;
      it.frame_id = 11'($urandom_range(RESP_ID_LO, RESP_ID_HI));
      it.frame_len = 4'($urandom_range(4, 8));
      it.len_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255))
                                                : 8'($urandom_range(3, 7));
      it.mode_byte = MODE_RESP;
      if ($urandom_range(0, 9) != 0)
        it.pid_byte = pids[$urandom_range(0, 4)];
      // break one header field now and then
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: it.is_standard = 1'b0;
          1: it.frame_id = 11'($urandom_range(0, 2047));
          2: it.frame_len = 4'($urandom_range(0, 3));
          3: it.mode_byte = 8'($urandom_range(0, 255));
          default: it.len_byte = 8'($urandom_range(0, 2));
        endcase
      end
    end else if (pick < 85) begin
      clock_ms += $urandom_range(0, per + per / 2 + 2);
      it.kind = KIND_TICK;
      it.now_ms = clock_ms;
      it.tx_ready = ($urandom_range(0, 3) != 0);
    end
    return it;
  endfunction

  task automatic send(input obd_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    {item_if.kind, item_if.now_ms, item_if.is_standard, item_if.frame_id,
     item_if.frame_len, item_if.len_byte, item_if.mode_byte, item_if.pid_byte,
     item_if.value_a, item_if.value_b, item_if.tx_ready} <= it;
    item_if.valid <= 1'b1;
    do @(posedge clk); while (item_if.ready !== 1'b1);
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      send(next_random_item(tracker.period_ms));
  endtask

  // Drain the block before touching the period.
  task automatic set_poll_period(input logic [15:0] p);
    item_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    tracker.set_period(p);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned spins;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    quiet = 1'b0;
    clock_ms = '0;
    item_if.valid <= 1'b0;
    {item_if.kind, item_if.now_ms, item_if.is_standard, item_if.frame_id,
     item_if.frame_len, item_if.len_byte, item_if.mode_byte, item_if.pid_byte,
     item_if.value_a, item_if.value_b, item_if.tx_ready} <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // poll timing at the reset period
    send(mk_tick(32'd50, 1'b1));
    send(mk_tick(32'd100, 1'b1));
    send(mk_tick(32'd200, 1'b0));
    send(mk_tick(32'd300, 1'b1));
    // every decode at its extremes, short two-byte frames
    send(mk_frame(1'b1, RESP_ID_LO, 4'd5, 8'd4, MODE_RESP, PID_RPM, 8'hFF, 8'hFF, 32'd310));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd4, 8'd4, MODE_RESP, PID_RPM, 8'h12, 8'h34, 32'd311));
    send(mk_frame(1'b1, RESP_ID_HI, 4'd4, 8'd3, MODE_RESP, PID_SPEED, 8'h00, 8'hAA, 32'd312));
    send(mk_frame(1'b1, 11'h7EA, 4'd5, 8'd3, MODE_RESP, PID_SPEED, 8'hFF, 8'h00, 32'd313));
    send(mk_frame(1'b1, 11'h7EB, 4'd4, 8'd3, MODE_RESP, PID_LOAD, 8'hFF, 8'h00, 32'd314));
    send(mk_frame(1'b1, 11'h7EC, 4'd4, 8'd3, MODE_RESP, PID_FUEL_LEVEL, 8'h01, 8'h00, 32'd315));
    send(mk_frame(1'b1, 11'h7ED, 4'd8, 8'd4, MODE_RESP, PID_FUEL_RATE, 8'hFF, 8'hFF, 32'd316));
    send(mk_frame(1'b1, 11'h7EE, 4'd4, 8'd4, MODE_RESP, PID_FUEL_RATE, 8'h01, 8'h02, 32'd317));
    send(mk_frame(1'b1, 11'h7EE, 4'd5, 8'd4, MODE_RESP, PID_FUEL_RATE, 8'h00, 8'h01, 32'd318));
    // rejected headers, each one step outside the filter
    send(mk_frame(1'b1, 11'h7E7, 4'd5, 8'd4, MODE_RESP, PID_SPEED, 8'h11, 8'h00, 32'd320));
    send(mk_frame(1'b1, 11'h7F0, 4'd5, 8'd4, MODE_RESP, PID_SPEED, 8'h11, 8'h00, 32'd321));
    send(mk_frame(1'b0, RESP_ID_LO, 4'd5, 8'd4, MODE_RESP, PID_SPEED, 8'h11, 8'h00, 32'd322));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd5, 8'd4, 8'h40, PID_SPEED, 8'h11, 8'h00, 32'd323));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd5, 8'd2, MODE_RESP, PID_SPEED, 8'h11, 8'h00, 32'd324));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd3, 8'd4, MODE_RESP, PID_SPEED, 8'h11, 8'h00, 32'd325));
    // length code above 8, unknown PID, largest length byte
    send(mk_frame(1'b1, RESP_ID_LO, 4'd15, 8'd4, MODE_RESP, PID_RPM, 8'h80, 8'h01, 32'd326));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd5, 8'd4, MODE_RESP, 8'h05, 8'h22, 8'h33, 32'd327));
    send(mk_frame(1'b1, RESP_ID_LO, 4'd5, 8'hFF, MODE_RESP, PID_LOAD, 8'h7F, 8'h00, 32'd328));
    // elapsed time across the wrap of the ms counter
    send(mk_tick(32'hFFFF_FFF0, 1'b1));
    send(mk_tick(32'h0000_0010, 1'b1));
    send(mk_tick(32'h0000_0060, 1'b1));
    clock_ms = 32'h0000_0060;

    run_random(300);
    set_poll_period(16'd0);
    run_random(250);
    set_poll_period(16'hFFFF);
    run_random(250);
    set_poll_period(16'($urandom_range(2, 5000)));
    run_random(200);
    set_poll_period(16'd1);
    quiet = 1'b1;
    run_random(200);

    item_if.valid <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (tracker.expected_results.size() != 0 && spins < 2000);
    repeat (5) @(posedge clk);
    if (tracker.expected_results.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               tracker.expected_results.size());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/obd_pkg.sv
rtl/core/obd_if.sv
rtl/core/obd_frame_dec.sv
rtl/core/obd_poll_sched.sv
rtl/core/obd_pid_poller_decoder_top.sv
test/tb_obd_pid_poller_decoder_top.sv
